### rtl/rmt_pkg.sv
// Shared types and constants for the running median tracker.
`timescale 1ns / 1ps

package rmt_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Opcode of an input transaction
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic rem;
    } rmt_cmd_t;

endpackage

### rtl/running_median_tracker.sv
// Top level of the running median tracker: control, cell row and result register.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_stall, opcode, value         | into block
//   result  | out_valid, out_stall, median, is_empty,   | out of block
//           | held_count, status                        |
//
// For each transaction the cell row inserts or removes in the
// accepting cycle, and the median is picked from the row into the result
// register in the next. Reset clears the held count and all handshake state;
// the cell contents are left as they are and only entries below the count are
// ever read. A stalled result holds the input side stalled as well.
`timescale 1ns / 1ps

module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] median,
    output logic               is_empty,
    output logic        [6:0]  held_count,
    output logic        [1:0]  status
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // Row of cells and their neighbour links
    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic                          cell_gt    [CAPACITY];
    logic        [CAPACITY-1:0]    cell_eq;

    logic signed [VALUE_WIDTH-1:0] key;
    logic signed [VALUE_WIDTH+31:0] key_wide;
    rmt_cmd_t                      cmd;
    logic                          accept;
    logic                          found;
    logic                          full;

    // Control and result registers
    logic [COUNT_W-1:0] count_reg,      count_next;
    logic               busy_reg,       busy_next;
    status_t            status_reg,     status_next;
    logic               out_valid_reg,  out_valid_next;
    logic signed [31:0] median_reg,     median_next;
    logic               is_empty_reg,   is_empty_next;
    logic [6:0]         held_count_reg, held_count_next;
    status_t            status_out_reg, status_out_next;

    logic [COUNT_W-1:0]            mid_count;
    logic [IDX_W-1:0]              mid_idx;
    logic signed [VALUE_WIDTH-1:0] mid_value;
    logic signed [VALUE_WIDTH+31:0] mid_wide;
    logic [COUNT_W+6:0]            count_wide;

    // Take the input as its low VALUE_WIDTH bits of the sign-extended word
    assign key_wide = {{VALUE_WIDTH{value[31]}}, value};
    assign key      = key_wide[VALUE_WIDTH-1:0];

    // Hold the input while the median is picked or a result is waiting
    assign in_stall = busy_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign found = |cell_eq;
    assign full  = (count_reg == FULL_COUNT);

    // Drop refused operations so the row is left unchanged
    assign cmd.ins = accept && (opcode == OP_INSERT) && !full;
    assign cmd.rem = accept && (opcode == OP_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_WIDTH-1:0] left_value;
            logic                          left_gt;
            logic signed [VALUE_WIDTH-1:0] right_value;

            if (gi == 0)
            begin : g_head
                assign left_value = '0;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_body
                assign left_value = cell_value[gi-1];
                assign left_gt    = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            rmt_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .COUNT_W     (COUNT_W),
                .INDEX       (gi)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .count       (count_reg),
                .key         (key),
                .left_value  (left_value),
                .left_gt     (left_gt),
                .right_value (right_value),
                .cell_value  (cell_value[gi]),
                .gt          (cell_gt[gi]),
                .eq          (cell_eq[gi])
            );
        end
    endgenerate

    // Lower median sits at index (count - 1) / 2
    assign mid_count  = count_reg - COUNT_W'(1);
    assign mid_idx    = IDX_W'(mid_count >> 1);
    assign mid_value  = cell_value[mid_idx];
    assign mid_wide   = {{32{mid_value[VALUE_WIDTH-1]}}, mid_value};
    assign count_wide = {7'd0, count_reg};

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        busy_next   = 1'b0;
        if (accept)
        begin
            busy_next = 1'b1;
            if (opcode == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (found)
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg - COUNT_W'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        median_next     = median_reg;
        is_empty_next   = is_empty_reg;
        held_count_next = held_count_reg;
        status_out_next = status_out_reg;
        if (busy_reg)
        begin
            // Advance the finished transaction into the result register
            out_valid_next  = 1'b1;
            is_empty_next   = (count_reg == '0);
            median_next     = (count_reg == '0) ? 32'sd0 : mid_wide[31:0];
            held_count_next = count_wide[6:0];
            status_out_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        median_reg     <= median_next;
        is_empty_reg   <= is_empty_next;
        held_count_reg <= held_count_next;
        status_out_reg <= status_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign is_empty   = is_empty_reg;
    assign held_count = held_count_reg;
    assign status     = status_out_reg;

endmodule

### rtl/rmt_cell.sv
// One cell of the sorted row: holds one entry, compares it and shifts it.
`timescale 1ns / 1ps

module rmt_cell
    import rmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_W     = 7,
    parameter int INDEX       = 0
)
(
    input  logic                          clk,
    input  rmt_cmd_t                      cmd,
    input  logic        [COUNT_W-1:0]     count,
    input  logic signed [VALUE_WIDTH-1:0] key,
    input  logic signed [VALUE_WIDTH-1:0] left_value,
    input  logic                          left_gt,
    input  logic signed [VALUE_WIDTH-1:0] right_value,
    output logic signed [VALUE_WIDTH-1:0] cell_value,
    output logic                          gt,
    output logic                          eq
);

    localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          occupied;
    logic                          at_tail;
    logic                          ge;

    assign occupied   = (MY_INDEX < count);
    assign at_tail    = (MY_INDEX == count);
    assign gt         = occupied && (key < value_reg);
    assign ge         = occupied && !(value_reg < key);
    assign eq         = occupied && (value_reg == key);
    assign cell_value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            // make room: shift right behind the insert point
            if (left_gt)
            begin
                value_next = left_value;
            end
            else if (gt || at_tail)
            begin
                value_next = key;
            end
        end
        else if (cmd.rem && ge)
        begin
            // close the gap from the first match onwards
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### bench/running_median_tracker_tb.sv
// Self-checking testbench for the running median tracker: stimulus, scoreboard and watchdog.
`timescale 1ns / 1ps

module running_median_tracker_tb;
    import rmt_pkg::*;

    typedef logic signed [31:0] word_t;

    // One transaction waiting to go into the block
    typedef struct packed {
        logic  op;
        word_t val;
        logic  wait_drain;
    } tx_item_t;

    // What the block must report after one transaction
    typedef struct packed {
        word_t      median;
        logic       empty;
        logic [6:0] held;
        status_t    status;
    } median_result_t;

    localparam int    CAPACITY     = CAPACITY_DEF;
    localparam int    RANDOM_ITEMS = 700;
    localparam int    IDLE_LIMIT   = 2000;
    localparam int    CALM_FIRST   = 300;
    localparam int    CALM_LAST    = 450;
    localparam word_t VAL_MAX      = 32'sh7FFF_FFFF;
    localparam word_t VAL_MIN      = 32'sh8000_0000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        opcode     = OP_INSERT;
    word_t       value      = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    word_t       median;
    logic        is_empty;
    logic [6:0]  held_count;
    logic [1:0]  status;

    tx_item_t       queued_ops[$];
    median_result_t due_results[$];
    word_t          held_values[$];   // sorted multiset as the block should hold it
    word_t          planned_bag[$];   // values the generator believes are held
    logic           drain_next = 1'b0;
    logic           calm       = 1'b0;
    int             sent_total = 0;
    int             recv_total = 0;
    int             err_count  = 0;
    int             idle_cycles = 0;

    running_median_tracker u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median     (median),
        .is_empty   (is_empty),
        .held_count (held_count),
        .status     (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one transaction to the sorted multiset and work out the report.
    // Inserts go after equal values; removes take the first equal entry.
    function automatic median_result_t track_median(logic op, word_t val);
        median_result_t r;
        int pos;
        r.status = ST_DONE;
        if (op == OP_INSERT)
        begin
            if (held_values.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                pos = held_values.size();
                while (pos > 0 && val < held_values[pos - 1])
                    pos--;
                held_values.insert(pos, val);
            end
        end
        else
        begin
            pos = 0;
            while (pos < held_values.size() && held_values[pos] != val)
                pos++;
            if (pos >= held_values.size())
                r.status = ST_ABSENT;
            else
                held_values.delete(pos);
        end
        r.held  = 7'(held_values.size());
        r.empty = (held_values.size() == 0);
        if (held_values.size() == 0)
            r.median = '0;
        else
            r.median = held_values[(held_values.size() + 1) / 2 - 1];
        return r;
    endfunction

    // Queue a transaction and keep the generator's bag in step with it
    task automatic queue_op(logic op, word_t val);
        tx_item_t item;
        int pos;
        item.op         = op;
        item.val        = val;
        item.wait_drain = drain_next;
        drain_next      = 1'b0;
        queued_ops.push_back(item);
        if (op == OP_INSERT)
        begin
            if (planned_bag.size() < CAPACITY)
                planned_bag.push_back(val);
        end
        else
        begin
            pos = 0;
            while (pos < planned_bag.size() && planned_bag[pos] != val)
                pos++;
            if (pos < planned_bag.size())
                planned_bag.delete(pos);
        end
    endtask

    // Mix of wide random values, a narrow band for duplicates, extremes and held values
    function automatic word_t pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return word_t'($urandom);
        if (sel < 7)
            return word_t'(int'($urandom_range(0, 15)) - 8);
        if (sel < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return word_t'(-1);
                default: return '0;
            endcase
        end
        if (planned_bag.size() > 0)
            return planned_bag[$urandom_range(0, planned_bag.size() - 1)];
        return word_t'($urandom);
    endfunction

    function automatic word_t pick_held();
        if (planned_bag.size() == 0)
            return pick_value();
        return planned_bag[$urandom_range(0, planned_bag.size() - 1)];
    endfunction

    // Driver: present the head of the queue, hold it while stalled, advance on acceptance.
    // A transaction marked wait_drain goes out only once every result has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= OP_INSERT;
            value    <= '0;
            calm     <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due_results.push_back(track_median(opcode, value));
                queued_ops.delete(0);
                sent_total++;
            end
            calm <= (sent_total >= CALM_FIRST && sent_total < CALM_LAST);
            if (!(in_valid && in_stall))
            begin
                if (queued_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 25)
                    && (!queued_ops[0].wait_drain || sent_total == recv_total))
                begin
                    in_valid <= 1'b1;
                    opcode   <= queued_ops[0].op;
                    value    <= queued_ops[0].val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, word_t want, word_t got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Monitor: take each result transaction and compare it with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        median_result_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            recv_total <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                recv_total <= recv_total + 1;
                if (due_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t ns: result with none expected, median %0d, count %0d",
                             $time, median, held_count);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("median", want.median, median);
                    check_field("is_empty", word_t'(want.empty), word_t'(is_empty));
                    check_field("held_count", word_t'(want.held), word_t'(held_count));
                    check_field("status", word_t'(2'(want.status)), word_t'(status));
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    // Watchdog: end the run if neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : run_sequence
        int target;
        int steps;

        // Directed: empty store, extremes, duplicates and absent removals
        queue_op(OP_REMOVE, '0);
        queue_op(OP_INSERT, VAL_MAX);
        queue_op(OP_INSERT, VAL_MIN);
        queue_op(OP_INSERT, '0);
        queue_op(OP_INSERT, word_t'(-1));
        queue_op(OP_INSERT, word_t'(-1));
        queue_op(OP_REMOVE, word_t'(5));
        queue_op(OP_REMOVE, word_t'(-1));
        queue_op(OP_REMOVE, VAL_MAX);
        queue_op(OP_REMOVE, VAL_MIN);
        queue_op(OP_REMOVE, word_t'(-1));
        queue_op(OP_REMOVE, '0);
        queue_op(OP_REMOVE, VAL_MIN);
        queue_op(OP_INSERT, word_t'(1));
        queue_op(OP_INSERT, word_t'(1));
        queue_op(OP_INSERT, VAL_MIN);
        queue_op(OP_REMOVE, word_t'(1));
        queue_op(OP_REMOVE, word_t'(1));
        queue_op(OP_REMOVE, word_t'(1));
        queue_op(OP_REMOVE, VAL_MIN);

        // Random: fill to capacity and beyond, drain to empty, and random walks
        target     = queued_ops.size() + RANDOM_ITEMS;
        drain_next = 1'b1;
        while (queued_ops.size() < target)
        begin
            if ($urandom_range(0, 2) == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 3))
                0:
                begin
                    while (planned_bag.size() < CAPACITY)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            queue_op(OP_REMOVE, pick_held());
                        else
                            queue_op(OP_INSERT, pick_value());
                    end
                    repeat ($urandom_range(1, 3))
                        queue_op(OP_INSERT, pick_value());
                end
                1:
                begin
                    while (planned_bag.size() != 0)
                    begin
                        steps = $urandom_range(0, 19);
                        if (steps < 2)
                            queue_op(OP_INSERT, pick_value());
                        else if (steps < 5)
                            queue_op(OP_REMOVE, pick_value());
                        else
                            queue_op(OP_REMOVE, pick_held());
                    end
                    queue_op(OP_REMOVE, pick_value());
                end
                default:
                begin
                    repeat ($urandom_range(10, 40))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            queue_op(OP_INSERT, pick_value());
                        else if ($urandom_range(0, 9) < 7)
                            queue_op(OP_REMOVE, pick_held());
                        else
                            queue_op(OP_REMOVE, pick_value());
                    end
                end
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every transaction is in, every result is back, then settle
        while (queued_ops.size() != 0 || in_valid)
            @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/rmt_pkg.sv
rtl/rmt_cell.sv
rtl/running_median_tracker.sv
bench/running_median_tracker_tb.sv
